// ===== src/psa_pkg.sv =====
// Package for the process slot allocator: field widths, default sizes,
// operation, status, slot state and sequencer codes, and the structs that
// the top level hands to the slot cells. Depends on nothing.
`default_nettype none

package psa_pkg;

  // Field widths of the request and response beats.
  localparam int unsigned OpW       = 2;
  localparam int unsigned IdW       = 16;
  localparam int unsigned AmountW   = 16;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned SlotIdxW  = 3;
  localparam int unsigned FreePoolW = 11;

  // Default table size and memory quota.
  localparam int unsigned SlotsDefault       = 8;
  localparam int unsigned TotalMemoryDefault = 1024;

  // First id handed out after reset and after a wrap.
  localparam logic [IdW-1:0] FirstId = IdW'(1);

  typedef enum logic [OpW-1:0] {
    OP_CREATE  = 2'd0,
    OP_ALLOC   = 2'd1,
    OP_RELEASE = 2'd2,
    OP_NOP     = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_AMOUNT    = 2'd2,
    STATUS_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    SLOT_FREE    = 2'd0,
    SLOT_CREATED = 2'd1,
    SLOT_RUNNING = 2'd2
  } slot_state_e;

  typedef enum logic {
    FSM_IDLE   = 1'b0,
    FSM_COMMIT = 1'b1
  } fsm_e;

  // Lookup broadcast to every cell in the cycle a request is accepted.
  typedef struct packed {
    logic           sample;
    logic           create;
    logic [IdW-1:0] proc_id;
  } look_t;

  // Update broadcast in the commit cycle; only the winning cell applies it.
  typedef struct packed {
    logic               commit;
    op_e                op;
    logic [IdW-1:0]     new_id;
    logic [AmountW-1:0] amount;
  } cmd_t;

endpackage

`default_nettype wire

// ===== src/psa_in_if.sv =====
// Request channel of the process slot allocator: valid/ready plus the
// operation, target id and amount. Depends on psa_pkg for field widths.
`default_nettype none

interface psa_in_if;

  logic                         valid;
  logic                         ready;
  logic [psa_pkg::OpW-1:0]      op;
  logic [psa_pkg::IdW-1:0]      proc_id;
  logic [psa_pkg::AmountW-1:0]  amount;

  modport source (output valid, output op, output proc_id, output amount, input ready);
  modport sink   (input valid, input op, input proc_id, input amount, output ready);

endinterface

`default_nettype wire

// ===== src/psa_out_if.sv =====
// Response channel of the process slot allocator: valid/ready plus status,
// new id, slot index and free pool. Depends on psa_pkg for field widths.
`default_nettype none

interface psa_out_if;

  logic                           valid;
  logic                           ready;
  logic [psa_pkg::StatusW-1:0]    status;
  logic [psa_pkg::IdW-1:0]        new_id;
  logic [psa_pkg::SlotIdxW-1:0]   slot_index;
  logic [psa_pkg::FreePoolW-1:0]  free_pool;

  modport source (output valid, output status, output new_id, output slot_index,
                  output free_pool, input ready);
  modport sink   (input valid, input status, input new_id, input slot_index,
                  input free_pool, output ready);

endinterface

`default_nettype wire

// ===== src/psa_cell.sv =====
// One process slot: state, id and allocated memory, plus the link of the
// priority chain that picks the lowest matching slot. Depends on psa_pkg.
`default_nettype none

module psa_cell #(
  parameter int unsigned MEM_W    = 11,
  parameter int unsigned IDX_W    = 3,
  parameter int unsigned CELL_IDX = 0
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire psa_pkg::look_t   look_i,
  input  wire psa_pkg::cmd_t    cmd_i,
  input  wire logic             claim_i,
  output logic                  claim_o,
  input  wire logic [MEM_W-1:0] mem_i,
  output logic      [MEM_W-1:0] mem_o,
  input  wire logic [IDX_W-1:0] idx_i,
  output logic      [IDX_W-1:0] idx_o
);

  psa_pkg::slot_state_e           state_q, state_d;
  logic [psa_pkg::IdW-1:0]        id_q, id_d;
  logic [MEM_W-1:0]               mem_q, mem_d;
  logic                           hit_q, hit_d;
  logic                           winner;

  // A hit is a free slot for a create, otherwise an occupied slot with the id.
  always_comb begin
    hit_d = hit_q;
    if (look_i.sample) begin
      if (look_i.create) begin
        hit_d = (state_q == psa_pkg::SLOT_FREE);
      end else begin
        hit_d = (state_q != psa_pkg::SLOT_FREE) && (id_q == look_i.proc_id);
      end
    end
  end

  // The lowest hit wins: every cell above it sees the claim already taken.
  assign winner  = hit_q && !claim_i;
  assign claim_o = claim_i || hit_q;
  assign mem_o   = mem_i | (winner ? mem_q : '0);
  assign idx_o   = winner ? IDX_W'(CELL_IDX) : idx_i;

  always_comb begin
    state_d = state_q;
    id_d    = id_q;
    mem_d   = mem_q;
    if (cmd_i.commit && winner) begin
      unique case (cmd_i.op)
        psa_pkg::OP_CREATE: begin
          state_d = psa_pkg::SLOT_CREATED;
          id_d    = cmd_i.new_id;
          mem_d   = '0;
        end
        psa_pkg::OP_ALLOC: begin
          state_d = psa_pkg::SLOT_RUNNING;
          mem_d   = mem_q + MEM_W'(cmd_i.amount);
        end
        psa_pkg::OP_RELEASE: begin
          state_d = psa_pkg::SLOT_FREE;
          mem_d   = '0;
        end
        default: begin
          state_d = state_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= psa_pkg::SLOT_FREE;
      id_q    <= '0;
      mem_q   <= '0;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      id_q    <= id_d;
      mem_q   <= mem_d;
      hit_q   <= hit_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/process_slot_allocator_core.sv =====
// Process slot allocator: a row of slot cells with a shared free pool and id counter.
// A request beat is accepted only while the controller is idle, and every cell registers its
// compare result as the beat is accepted; the commit step then updates the winning cell and
// registers the response, and waits while a stalled response still holds the output register.
// A new request is not accepted until the previous one has been committed.
// Reset: all slots free, pool full, id counter at 1; no clearing pass is needed.
`default_nettype none

module process_slot_allocator_core #(
  parameter int unsigned SLOTS        = psa_pkg::SlotsDefault,
  parameter int unsigned TOTAL_MEMORY = psa_pkg::TotalMemoryDefault
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  psa_in_if.sink     in_i,
  psa_out_if.source  out_o
);

  localparam int unsigned MemW  = $clog2(TOTAL_MEMORY + 1);
  localparam int unsigned IdxW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned AmtW  = psa_pkg::AmountW;
  localparam int unsigned SiW   = psa_pkg::SlotIdxW;
  localparam int unsigned FpW   = psa_pkg::FreePoolW;

  psa_pkg::fsm_e                    state_q, state_d;
  psa_pkg::op_e                     op_q;
  logic [AmtW-1:0]                  amount_q;
  logic [MemW-1:0]                  pool_q, pool_d;
  logic [psa_pkg::IdW-1:0]          id_cnt_q, id_cnt_d;

  logic                             out_valid_q, out_valid_d;
  psa_pkg::status_e                 status_q, status_d;
  logic [psa_pkg::IdW-1:0]          new_id_q, new_id_d;
  logic [SiW-1:0]                   slot_q, slot_d;
  logic [FpW-1:0]                   free_q, free_d;

  psa_pkg::look_t                   look;
  psa_pkg::cmd_t                    cmd;
  logic                             accept;
  logic                             found;
  logic                             amount_bad;
  logic                             go;

  logic [SLOTS:0]                   claim;
  logic [MemW-1:0]                  mem_chain [SLOTS+1];
  logic [IdxW-1:0]                  idx_chain [SLOTS+1];

  assign in_i.ready = (state_q == psa_pkg::FSM_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  assign look.sample  = accept;
  assign look.create  = (psa_pkg::op_e'(in_i.op) == psa_pkg::OP_CREATE);
  assign look.proc_id = in_i.proc_id;

  assign claim[0]     = 1'b0;
  assign mem_chain[0] = '0;
  assign idx_chain[0] = '0;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    psa_cell #(
      .MEM_W    (MemW),
      .IDX_W    (IdxW),
      .CELL_IDX (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .look_i  (look),
      .cmd_i   (cmd),
      .claim_i (claim[g]),
      .claim_o (claim[g+1]),
      .mem_i   (mem_chain[g]),
      .mem_o   (mem_chain[g+1]),
      .idx_i   (idx_chain[g]),
      .idx_o   (idx_chain[g+1])
    );
  end

  assign found      = claim[SLOTS];
  assign amount_bad = (amount_q == '0) || (amount_q > AmtW'(pool_q));

  always_comb begin
    state_d     = state_q;
    pool_d      = pool_q;
    id_cnt_d    = id_cnt_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    new_id_d    = new_id_q;
    slot_d      = slot_q;
    free_d      = free_q;
    go          = 1'b0;

    unique case (state_q)
      psa_pkg::FSM_IDLE: begin
        if (out_valid_q && out_o.ready) begin
          out_valid_d = 1'b0;
        end
        if (accept) begin
          state_d = psa_pkg::FSM_COMMIT;
        end
      end
      psa_pkg::FSM_COMMIT: begin
        // The commit waits until the response register is free or being drained.
        if (!out_valid_q || out_o.ready) begin
          state_d     = psa_pkg::FSM_IDLE;
          out_valid_d = 1'b1;
          status_d    = psa_pkg::STATUS_OK;
          new_id_d    = '0;
          slot_d      = '0;
          unique case (op_q)
            psa_pkg::OP_CREATE: begin
              if (found) begin
                go       = 1'b1;
                new_id_d = id_cnt_q;
                slot_d   = SiW'(idx_chain[SLOTS]);
                id_cnt_d = (id_cnt_q == '1) ? psa_pkg::FirstId : id_cnt_q + 1'b1;
              end else begin
                status_d = psa_pkg::STATUS_FULL;
              end
            end
            psa_pkg::OP_ALLOC: begin
              if (amount_bad) begin
                status_d = psa_pkg::STATUS_AMOUNT;
              end else if (found) begin
                go     = 1'b1;
                slot_d = SiW'(idx_chain[SLOTS]);
                pool_d = pool_q - MemW'(amount_q);
              end else begin
                status_d = psa_pkg::STATUS_NOT_FOUND;
              end
            end
            psa_pkg::OP_RELEASE: begin
              if (found) begin
                go     = 1'b1;
                slot_d = SiW'(idx_chain[SLOTS]);
                pool_d = pool_q + mem_chain[SLOTS];
              end else begin
                status_d = psa_pkg::STATUS_NOT_FOUND;
              end
            end
            default: begin
              status_d = psa_pkg::STATUS_OK;
            end
          endcase
          free_d = FpW'(pool_d);
        end
      end
      default: begin
        state_d = psa_pkg::FSM_IDLE;
      end
    endcase
  end

  assign cmd.commit = go;
  assign cmd.op     = op_q;
  assign cmd.new_id = id_cnt_q;
  assign cmd.amount = amount_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= psa_pkg::FSM_IDLE;
      pool_q      <= MemW'(TOTAL_MEMORY);
      id_cnt_q    <= psa_pkg::FirstId;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pool_q      <= pool_d;
      id_cnt_q    <= id_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= psa_pkg::op_e'(in_i.op);
      amount_q <= in_i.amount;
    end
    status_q <= status_d;
    new_id_q <= new_id_d;
    slot_q   <= slot_d;
    free_q   <= free_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = status_q;
  assign out_o.new_id     = new_id_q;
  assign out_o.slot_index = slot_q;
  assign out_o.free_pool  = free_q;

endmodule

`default_nettype wire
